// File: sv/kmde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmde_pkg
// Shared widths and result type for the key matrix debounce block.
// ----------------------------------------------------------------------------
package kmde_pkg;

  localparam int ROW_W = 3;
  localparam int KEY_W = 8;

  // Debounced state of one row and its edge masks.
  typedef struct packed {
    logic [KEY_W-1:0] stable;
    logic [KEY_W-1:0] pressed;
    logic [KEY_W-1:0] released;
  } kmde_res_t;

endpackage

// File: sv/kmde_row_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmde_row_update
// Shift one raw sample into a row's history and derive the debounced byte
// and its press and release edges.
// ----------------------------------------------------------------------------
module kmde_row_update #(
  parameter int CONFIRM      = 3,
  parameter int KEYS_PER_ROW = 8
) (
  input  logic [CONFIRM*kmde_pkg::KEY_W-1:0] entry_in,
  input  logic [kmde_pkg::KEY_W-1:0]         sample,
  output logic [CONFIRM*kmde_pkg::KEY_W-1:0] entry_out,
  output kmde_pkg::kmde_res_t                res
);
  import kmde_pkg::*;

  localparam int HIST = CONFIRM - 1;
  localparam logic [KEY_W-1:0] COL_MASK =
    (KEYS_PER_ROW >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((1 << KEYS_PER_ROW) - 1);

  logic [KEY_W-1:0] smp;
  logic [KEY_W-1:0] prev;
  logic [KEY_W-1:0] next;
  logic [KEY_W-1:0] ones;
  logic [KEY_W-1:0] zeros;
  logic [KEY_W-1:0] changed;

  // entry layout: debounced byte in the low slice, then the previous
  // samples, newest first
  always_comb begin
    smp   = sample & COL_MASK;
    prev  = entry_in[KEY_W-1:0];
    ones  = smp;
    zeros = ~smp;
    for (int i = 0; i < HIST; i++) begin
      ones  = ones & entry_in[KEY_W*(i+1) +: KEY_W];
      zeros = zeros & ~entry_in[KEY_W*(i+1) +: KEY_W];
    end
    next    = (prev | ones) & ~zeros & COL_MASK;
    changed = prev ^ next;

    entry_out = '0;
    entry_out[KEY_W-1:0]     = next;
    entry_out[KEY_W +: KEY_W] = smp;
    for (int i = 1; i < HIST; i++) begin
      entry_out[KEY_W*(i+1) +: KEY_W] = entry_in[KEY_W*i +: KEY_W];
    end

    res.stable   = next;
    res.pressed  = changed & next;
    res.released = changed & ~next;
  end

endmodule

// File: sv/key_matrix_debounce_edge.sv
`timescale 1ns / 1ps
// Pipeline: an accepted input beat passes the read stage, then the output register.
// Throughput: one row per cycle while out_stall does not hold the output; the single
//   read port of the row store, read in the cycle a beat is taken, sets that figure.
// Reset: synchronous, clears per-row valid bits, so every row reads as zero
//   history and zero debounced state; no clearing pass.
// ----------------------------------------------------------------------------
// key_matrix_debounce_edge
// Debounce for a scanned key matrix with press and release edge detection.
// ----------------------------------------------------------------------------
module key_matrix_debounce_edge #(
  parameter int ROWS         = 8,
  parameter int CONFIRM      = 3,
  parameter int KEYS_PER_ROW = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [kmde_pkg::ROW_W-1:0]  row,
  input  logic [kmde_pkg::KEY_W-1:0]  raw_keys,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [kmde_pkg::ROW_W-1:0]  row_out,
  output logic [kmde_pkg::KEY_W-1:0]  stable_keys,
  output logic [kmde_pkg::KEY_W-1:0]  pressed,
  output logic [kmde_pkg::KEY_W-1:0]  released
);
  import kmde_pkg::*;

  // one memory word per row: debounced byte plus CONFIRM-1 past samples
  localparam int EW    = CONFIRM * KEY_W;
  localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [KEY_W-1:0] COL_MASK =
    (KEYS_PER_ROW >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((1 << KEYS_PER_ROW) - 1);

  logic [EW-1:0]    mem [ROWS];
  logic [ROWS-1:0]  vld;

  // read stage
  logic             s1_valid;
  logic [ROW_W-1:0] s1_row;
  logic [KEY_W-1:0] s1_sample;
  logic             s1_ok;
  logic [EW-1:0]    rdata;
  logic             rvld;
  logic             fwd_hit;
  logic [EW-1:0]    fwd_data;

  logic             adv;
  logic             in_acc;
  logic             row_ok;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             wr_en;
  logic [EW-1:0]    entry_cur;
  logic [EW-1:0]    entry_new;
  kmde_res_t        res;

  // the output register frees when empty or when its beat is taken
  assign adv      = !out_valid || !out_stall;
  assign in_stall = s1_valid && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign row_ok   = 5'(row) < 5'(ROWS);
  assign rd_idx   = IDX_W'(row);
  assign wr_idx   = IDX_W'(s1_row);
  assign wr_en    = s1_valid && adv && s1_ok;

  // take the freshest copy: a write landing on the edge of the read wins,
  // otherwise an unwritten row reads as zero
  always_comb begin
    if (fwd_hit) begin
      entry_cur = fwd_data;
    end else if (rvld) begin
      entry_cur = rdata;
    end else begin
      entry_cur = '0;
    end
  end

  kmde_row_update #(
    .CONFIRM      (CONFIRM),
    .KEYS_PER_ROW (KEYS_PER_ROW)
  ) u_update (
    .entry_in  (entry_cur),
    .sample    (s1_sample),
    .entry_out (entry_new),
    .res       (res)
  );

  // row store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= entry_new;
    end
    if (in_acc) begin
      rdata    <= mem[rd_idx];
      fwd_data <= entry_new;
    end
  end

  // read-stage control and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      s1_valid <= 1'b0;
      rvld     <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_idx] <= 1'b1;
      end
      if (in_acc) begin
        s1_valid <= 1'b1;
        rvld     <= vld[rd_idx];
        // same row written on this edge: the memory returns the old word
        fwd_hit  <= wr_en && (wr_idx == rd_idx);
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_row    <= row;
      s1_sample <= raw_keys & COL_MASK;
      s1_ok     <= row_ok;
    end
  end

  // output register: hold while stalled, advance otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      row_out <= s1_row;
      if (s1_ok) begin
        stable_keys <= res.stable;
        pressed     <= res.pressed;
        released    <= res.released;
      end else begin
        // row beyond the matrix: report nothing, leave state untouched
        stable_keys <= '0;
        pressed     <= '0;
        released    <= '0;
      end
    end
  end

  // a key cannot be pressed and released in the same beat
  a_edges_disjoint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pressed & released) == '0)
    else $error("pressed and released overlap");

  // press edges lie within, release edges outside, the debounced byte
  a_edges_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((pressed & ~stable_keys) == '0) && ((released & stable_keys) == '0))
    else $error("edge mask disagrees with debounced byte");

  // columns beyond the matrix never read as pressed
  a_cols_masked: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (stable_keys & ~COL_MASK) == '0)
    else $error("unused column set");

  // rows beyond the matrix return an empty result
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (5'(row_out) >= 5'(ROWS)) |->
      (stable_keys == '0) && (pressed == '0) && (released == '0))
    else $error("out-of-range row returned data");

  // a same-row write on the edge of the read is always forwarded
  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    in_acc && wr_en && (wr_idx == rd_idx) |=> fwd_hit)
    else $error("missed forward of a same-row write");

endmodule
